### src/rect_copy_fill_address_engine_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the rectangle copy and fill address engine
// Shared forms for the concurrent checks on the engine's ports.
// ---------------------------------------------------------------------------
`ifndef RECT_COPY_FILL_ADDRESS_ENGINE_MACROS_SVH
`define RECT_COPY_FILL_ADDRESS_ENGINE_MACROS_SVH

// Implication in the same cycle, checked only outside reset.
`define RCFAE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rcfae check failed");

// Implication into the next cycle, checked only outside reset.
`define RCFAE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rcfae check failed");

// Implication into the next cycle, checked in reset as well.
`define RCFAE_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("rcfae check failed");

`endif

### src/rcfae_pkg.sv
// ---------------------------------------------------------------------------
// rcfae_pkg
// Types, constants and helper functions of the copy and fill address engine.
// ---------------------------------------------------------------------------
package rcfae_pkg;

    localparam int DIM_BITS          = 13;
    localparam int COORD_BITS        = 12;
    localparam int PROD_BITS         = COORD_BITS + DIM_BITS;
    localparam int PIXEL_BITS        = 32;
    localparam int OUT_ADDR_BITS     = 24;
    localparam int MAX_DIM           = 4096;
    localparam int ADDR_BITS_DEFAULT = 24;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 13;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_SRC_WIDTH   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SRC_HEIGHT  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DST_WIDTH   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DST_HEIGHT  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BYTE_PIXELS = 3'd4;

    localparam logic [DIM_BITS-1:0] RESET_SRC_WIDTH  = 13'd400;
    localparam logic [DIM_BITS-1:0] RESET_SRC_HEIGHT = 13'd300;
    localparam logic [DIM_BITS-1:0] RESET_DST_WIDTH  = 13'd400;
    localparam logic [DIM_BITS-1:0] RESET_DST_HEIGHT = 13'd300;

    localparam logic [1:0] CMD_START_COPY = 2'd0;
    localparam logic [1:0] CMD_START_FILL = 2'd1;
    localparam logic [1:0] CMD_STEP       = 2'd2;

    localparam int S_TDATA_BITS = 112;
    localparam int S_TUSER_BITS = 3;
    localparam int M_TDATA_BITS = 80;

    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

    typedef enum logic {
        OP_START,
        OP_STEP
    } op_kind_t;

    typedef struct packed {
        logic [DIM_BITS-1:0] src_width;
        logic [DIM_BITS-1:0] src_height;
        logic [DIM_BITS-1:0] dst_width;
        logic [DIM_BITS-1:0] dst_height;
        logic                byte_pixels;
    } cfg_t;

    typedef struct packed {
        op_kind_t              kind;
        logic                  is_fill;
        logic [DIM_BITS-1:0]   run_w;
        logic [DIM_BITS-1:0]   run_h;
        logic [PROD_BITS-1:0]  src_prod;
        logic [COORD_BITS-1:0] src_off;
        logic [PROD_BITS-1:0]  dst_prod;
        logic [COORD_BITS-1:0] dst_off;
        logic [PIXEL_BITS-1:0] fill;
    } op_t;

    function automatic logic [DIM_BITS-1:0] clip_span(
        input logic [DIM_BITS-1:0]   want,
        input logic [COORD_BITS-1:0] start,
        input logic [DIM_BITS-1:0]   edge_pos
    );
        logic [DIM_BITS-1:0] room;
        room = ({1'b0, start} >= edge_pos) ? '0 : edge_pos - {1'b0, start};
        return (want < room) ? want : room;
    endfunction

    function automatic logic [DIM_BITS-1:0] sat_dim(input logic [DIM_BITS-1:0] v);
        return (v > DIM_BITS'(MAX_DIM)) ? DIM_BITS'(MAX_DIM) : v;
    endfunction

endpackage

### src/rcfae_front.sv
// ---------------------------------------------------------------------------
// rcfae_front
// Accepts input items, decodes the command and prepares job parameters.
// ---------------------------------------------------------------------------
module rcfae_front (
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [rcfae_pkg::S_TDATA_BITS-1:0]   s_tdata,
    input  logic [rcfae_pkg::S_TUSER_BITS-1:0]   s_tuser,
    input  rcfae_pkg::cfg_t                      cfg,
    input  logic                                 q_ready,
    output logic                                 q_push,
    output rcfae_pkg::op_t                       q_op
);

    logic [1:0]                             cmd;
    logic                                   full_rect;
    logic [rcfae_pkg::COORD_BITS-1:0]       src_x;
    logic [rcfae_pkg::COORD_BITS-1:0]       src_y;
    logic [rcfae_pkg::COORD_BITS-1:0]       dst_x;
    logic [rcfae_pkg::COORD_BITS-1:0]       dst_y;
    logic [rcfae_pkg::DIM_BITS-1:0]         rect_w;
    logic [rcfae_pkg::DIM_BITS-1:0]         rect_h;
    logic [rcfae_pkg::PIXEL_BITS-1:0]       fill_value;
    logic                                   fill_job;
    logic [rcfae_pkg::DIM_BITS-1:0]         clip_w;
    logic [rcfae_pkg::DIM_BITS-1:0]         clip_h;
    logic [rcfae_pkg::DIM_BITS-1:0]         raw_w;
    logic [rcfae_pkg::DIM_BITS-1:0]         raw_h;

    assign cmd        = s_tuser[1:0];
    assign full_rect  = s_tuser[2];
    assign src_x      = s_tdata[11:0];
    assign src_y      = s_tdata[23:12];
    assign dst_x      = s_tdata[35:24];
    assign dst_y      = s_tdata[47:36];
    assign rect_w     = s_tdata[60:48];
    assign rect_h     = s_tdata[73:61];
    assign fill_value = s_tdata[105:74];

    assign s_tready = q_ready;
    assign fill_job = (cmd == rcfae_pkg::CMD_START_FILL);
    assign clip_w   = rcfae_pkg::clip_span(rect_w, dst_x, cfg.dst_width);
    assign clip_h   = rcfae_pkg::clip_span(rect_h, dst_y, cfg.dst_height);

    always_comb begin
        raw_w          = clip_w;
        raw_h          = clip_h;
        q_op.kind      = rcfae_pkg::OP_STEP;
        q_op.is_fill   = fill_job;
        q_op.src_prod  = '0;
        q_op.src_off   = '0;
        q_op.dst_prod  = rcfae_pkg::PROD_BITS'(dst_y)
                       * rcfae_pkg::PROD_BITS'(cfg.dst_width);
        q_op.dst_off   = dst_x;
        if (fill_job && full_rect) begin
            raw_w         = cfg.dst_width;
            raw_h         = cfg.dst_height;
            q_op.dst_prod = '0;
            q_op.dst_off  = '0;
        end else if (full_rect) begin
            raw_w = cfg.src_width;
            raw_h = cfg.src_height;
        end else if (!fill_job) begin
            q_op.src_prod = rcfae_pkg::PROD_BITS'(src_y)
                          * rcfae_pkg::PROD_BITS'(cfg.src_width);
            q_op.src_off  = src_x;
        end
        q_op.run_w = rcfae_pkg::sat_dim(raw_w);
        q_op.run_h = rcfae_pkg::sat_dim(raw_h);
        q_op.fill  = cfg.byte_pixels ? {24'd0, fill_value[7:0]} : fill_value;

        unique case (cmd) inside
            rcfae_pkg::CMD_START_COPY, rcfae_pkg::CMD_START_FILL: begin
                q_op.kind = rcfae_pkg::OP_START;
                q_push    = s_tvalid && q_ready;
            end
            rcfae_pkg::CMD_STEP: begin
                q_op.kind = rcfae_pkg::OP_STEP;
                q_push    = s_tvalid && q_ready;
            end
            default: begin
                q_push = 1'b0;
            end
        endcase
    end

endmodule

### src/rcfae_queue.sv
// ---------------------------------------------------------------------------
// rcfae_queue
// Short first-in first-out queue of decoded operations between the two parts.
// ---------------------------------------------------------------------------
module rcfae_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  rcfae_pkg::op_t  push_op,
    output logic            ready,
    input  logic            pop,
    output logic            valid,
    output rcfae_pkg::op_t  head_op
);

    rcfae_pkg::op_t                        entries [rcfae_pkg::QUEUE_DEPTH];
    logic [rcfae_pkg::QUEUE_PTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [rcfae_pkg::QUEUE_PTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [rcfae_pkg::QUEUE_PTR_BITS:0]    count_reg, count_next;

    assign ready   = (count_reg != (rcfae_pkg::QUEUE_PTR_BITS + 1)'(rcfae_pkg::QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign head_op = entries[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries[wr_ptr_reg] <= push_op;
        end
    end

endmodule

### src/rcfae_back.sv
// ---------------------------------------------------------------------------
// rcfae_back
// Runs the current job: walks the rectangle row by row and drives results.
// ---------------------------------------------------------------------------
module rcfae_back #(
    parameter int ADDR_BITS = rcfae_pkg::ADDR_BITS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  rcfae_pkg::cfg_t                     cfg,
    input  logic                                q_valid,
    input  rcfae_pkg::op_t                      q_op,
    output logic                                q_pop,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [rcfae_pkg::M_TDATA_BITS-1:0]  m_tdata,
    output logic                                m_tuser,
    output logic                                m_tlast
);

    typedef logic [ADDR_BITS-1:0] addr_t;

    logic                                   active_reg, active_next;
    logic                                   job_fill_reg, job_fill_next;
    logic [rcfae_pkg::DIM_BITS-1:0]         row_reg, row_next;
    logic [rcfae_pkg::DIM_BITS-1:0]         col_reg, col_next;
    logic [rcfae_pkg::DIM_BITS-1:0]         run_w_reg, run_w_next;
    logic [rcfae_pkg::DIM_BITS-1:0]         run_h_reg, run_h_next;
    addr_t                                  src_base_reg, src_base_next;
    addr_t                                  dst_base_reg, dst_base_next;
    logic [rcfae_pkg::PIXEL_BITS-1:0]       fill_reg, fill_next;

    logic                                   out_valid_reg, out_valid_next;
    logic [rcfae_pkg::OUT_ADDR_BITS-1:0]    out_src_reg, out_src_next;
    logic [rcfae_pkg::OUT_ADDR_BITS-1:0]    out_dst_reg, out_dst_next;
    logic [rcfae_pkg::PIXEL_BITS-1:0]       out_pixel_reg, out_pixel_next;
    logic                                   out_fill_reg, out_fill_next;
    logic                                   out_last_reg, out_last_next;

    logic                                   take;
    addr_t                                  src_addr;
    addr_t                                  dst_addr;
    logic [rcfae_pkg::DIM_BITS-1:0]         col_plus;
    logic [rcfae_pkg::DIM_BITS-1:0]         row_plus;
    logic                                   row_done;
    logic                                   job_done;

    assign take     = q_valid && (!out_valid_reg || m_tready);
    assign q_pop    = take;
    assign src_addr = ADDR_BITS'(64'(src_base_reg) + 64'(col_reg));
    assign dst_addr = ADDR_BITS'(64'(dst_base_reg) + 64'(col_reg));
    assign col_plus = col_reg + 1'b1;
    assign row_plus = row_reg + 1'b1;
    assign row_done = (col_plus == run_w_reg);
    assign job_done = row_done && (row_plus == run_h_reg);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_pixel_reg, out_dst_reg, out_src_reg};
    assign m_tuser  = out_fill_reg;
    assign m_tlast  = out_last_reg;

    always_comb begin
        active_next    = active_reg;
        job_fill_next  = job_fill_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        run_w_next     = run_w_reg;
        run_h_next     = run_h_reg;
        src_base_next  = src_base_reg;
        dst_base_next  = dst_base_reg;
        fill_next      = fill_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_src_next   = out_src_reg;
        out_dst_next   = out_dst_reg;
        out_pixel_next = out_pixel_reg;
        out_fill_next  = out_fill_reg;
        out_last_next  = out_last_reg;

        if (take) begin
            unique case (q_op.kind)
                rcfae_pkg::OP_START: begin
                    job_fill_next = q_op.is_fill;
                    run_w_next    = q_op.run_w;
                    run_h_next    = q_op.run_h;
                    row_next      = '0;
                    col_next      = '0;
                    src_base_next = ADDR_BITS'(64'(q_op.src_prod) + 64'(q_op.src_off));
                    dst_base_next = ADDR_BITS'(64'(q_op.dst_prod) + 64'(q_op.dst_off));
                    fill_next     = q_op.fill;
                    active_next   = (q_op.run_w != '0) && (q_op.run_h != '0);
                end
                rcfae_pkg::OP_STEP: begin
                    if (active_reg) begin
                        out_valid_next = 1'b1;
                        out_src_next   = job_fill_reg ? '0
                                       : rcfae_pkg::OUT_ADDR_BITS'(64'(src_addr));
                        out_dst_next   = rcfae_pkg::OUT_ADDR_BITS'(64'(dst_addr));
                        out_pixel_next = job_fill_reg ? fill_reg : '0;
                        out_fill_next  = job_fill_reg;
                        out_last_next  = job_done;
                        col_next       = col_plus;
                        if (row_done) begin
                            col_next      = '0;
                            row_next      = row_plus;
                            src_base_next = ADDR_BITS'(64'(src_base_reg) + 64'(cfg.src_width));
                            dst_base_next = ADDR_BITS'(64'(dst_base_reg) + 64'(cfg.dst_width));
                            if (job_done) begin
                                active_next = 1'b0;
                            end
                        end
                    end
                end
                default: begin
                    active_next = active_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            job_fill_reg  <= 1'b0;
            row_reg       <= '0;
            col_reg       <= '0;
            run_w_reg     <= '0;
            run_h_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            active_reg    <= active_next;
            job_fill_reg  <= job_fill_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            run_w_reg     <= run_w_next;
            run_h_reg     <= run_h_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        src_base_reg  <= src_base_next;
        dst_base_reg  <= dst_base_next;
        fill_reg      <= fill_next;
        out_src_reg   <= out_src_next;
        out_dst_reg   <= out_dst_next;
        out_pixel_reg <= out_pixel_next;
        out_fill_reg  <= out_fill_next;
        out_last_reg  <= out_last_next;
    end

endmodule

### src/rect_copy_fill_address_engine.sv
// ---------------------------------------------------------------------------
// rect_copy_fill_address_engine
// Address engine of a 2D blitter for rectangle copies and fills.
//
// Channel   Direction  Item
// s_        in         command: start copy, start fill or step one pixel
// m_        out        one pixel: source and destination index, fill value
// cfg_      in         register write: surface sizes and pixel mode
//
// One item is taken per cycle while the queue has room; a step passes through the
// four-entry queue and then the output register before its result shows.
// Reset is synchronous: registers return to their defaults, the queue
// empties and no job is running.
// A stalled output holds its item; the queue then stores up to four more
// commands before s_tready drops.
// ---------------------------------------------------------------------------
module rect_copy_fill_address_engine #(
    parameter int ADDR_BITS = rcfae_pkg::ADDR_BITS_DEFAULT
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // src_x, src_y, dst_x, dst_y, rect_w, rect_h, fill_value
    input  logic [rcfae_pkg::S_TDATA_BITS-1:0]     s_tdata,
    // command, full_rect
    input  logic [rcfae_pkg::S_TUSER_BITS-1:0]     s_tuser,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // src_address, dst_address, pixel_value
    output logic [rcfae_pkg::M_TDATA_BITS-1:0]     m_tdata,
    // is_fill
    output logic                                   m_tuser,
    output logic                                   m_tlast,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    input  logic                                   cfg_wr_en,
    input  logic [rcfae_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [rcfae_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);

    rcfae_pkg::cfg_t  cfg_reg, cfg_next;
    logic             q_ready;
    logic             q_push;
    logic             q_pop;
    logic             q_valid;
    rcfae_pkg::op_t   push_op;
    rcfae_pkg::op_t   head_op;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                rcfae_pkg::CFG_SRC_WIDTH:   cfg_next.src_width   = cfg_wdata;
                rcfae_pkg::CFG_SRC_HEIGHT:  cfg_next.src_height  = cfg_wdata;
                rcfae_pkg::CFG_DST_WIDTH:   cfg_next.dst_width   = cfg_wdata;
                rcfae_pkg::CFG_DST_HEIGHT:  cfg_next.dst_height  = cfg_wdata;
                rcfae_pkg::CFG_BYTE_PIXELS: cfg_next.byte_pixels = cfg_wdata[0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.src_width   <= rcfae_pkg::RESET_SRC_WIDTH;
            cfg_reg.src_height  <= rcfae_pkg::RESET_SRC_HEIGHT;
            cfg_reg.dst_width   <= rcfae_pkg::RESET_DST_WIDTH;
            cfg_reg.dst_height  <= rcfae_pkg::RESET_DST_HEIGHT;
            cfg_reg.byte_pixels <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    rcfae_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg      (cfg_reg),
        .q_ready  (q_ready),
        .q_push   (q_push),
        .q_op     (push_op)
    );

    rcfae_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .push_op (push_op),
        .ready   (q_ready),
        .pop     (q_pop),
        .valid   (q_valid),
        .head_op (head_op)
    );

    rcfae_back #(
        .ADDR_BITS (ADDR_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_op     (head_op),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

### src/rcfae_checker.sv
// ---------------------------------------------------------------------------
// rcfae_checker
// Port-level checks on the result channel of the address engine.
// ---------------------------------------------------------------------------
`include "rect_copy_fill_address_engine_macros.svh"

module rcfae_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [rcfae_pkg::M_TDATA_BITS-1:0]  m_tdata,
    input logic                                m_tuser,
    input logic                                m_tlast
);

    // A fill item never carries a source index.
    `RCFAE_ASSERT_SAME(fill_src_zero, aclk, aresetn, m_tvalid && m_tuser, m_tdata[23:0] == '0)

    // A copy item never carries a pixel value.
    `RCFAE_ASSERT_SAME(copy_pixel_zero, aclk, aresetn, m_tvalid && !m_tuser, m_tdata[79:48] == '0)

    // A held item keeps its payload until it is taken.
    `RCFAE_ASSERT_NEXT(out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // No item is shown in the cycle after reset.
    `RCFAE_ASSERT_ALWAYS_NEXT(reset_quiet, aclk, !aresetn, !m_tvalid)

endmodule

bind rect_copy_fill_address_engine rcfae_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

### tb/tb_rect_copy_fill_address_engine.sv
// ---------------------------------------------------------------------------
// Testbench for rect_copy_fill_address_engine
// Commands go in through a queue-fed driver that sends them in random bursts.
// An internal model of the engine predicts every pixel item as each command
// is accepted, and a monitor compares each output item field by field while
// the receiver stalls on its own pattern. Surface registers change between
// phases, once the engine has gone quiet.
// ---------------------------------------------------------------------------
module tb_rect_copy_fill_address_engine;
    import rcfae_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int RUN_LIMIT    = 600000;
    localparam int DRAIN_CYCLES = 24;
    localparam int PHASE_ITEMS  = 150;

    typedef struct {
        logic [1:0]            cmd;
        logic                  full;
        logic [COORD_BITS-1:0] sx;
        logic [COORD_BITS-1:0] sy;
        logic [COORD_BITS-1:0] dx;
        logic [COORD_BITS-1:0] dy;
        logic [DIM_BITS-1:0]   rw;
        logic [DIM_BITS-1:0]   rh;
        logic [PIXEL_BITS-1:0] fv;
    } blit_cmd_t;

    typedef struct {
        logic [OUT_ADDR_BITS-1:0] src_addr;
        logic [OUT_ADDR_BITS-1:0] dst_addr;
        logic                     is_fill;
        logic [PIXEL_BITS-1:0]    value;
        logic                     last;
    } pixel_t;

    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic [S_TDATA_BITS-1:0]   s_tdata   = '0;
    logic [S_TUSER_BITS-1:0]   s_tuser   = '0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [M_TDATA_BITS-1:0]   m_tdata;
    logic                      m_tuser;
    logic                      m_tlast;
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_wdata = '0;

    rect_copy_fill_address_engine dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Surface registers as last written.
    int src_w  = RESET_SRC_WIDTH;
    int src_h  = RESET_SRC_HEIGHT;
    int dst_w  = RESET_DST_WIDTH;
    int dst_h  = RESET_DST_HEIGHT;
    int byte_px = 0;

    // Model of the running job.
    logic                     job_busy = 1'b0;
    logic                     job_fill = 1'b0;
    int                       job_row = 0;
    int                       job_col = 0;
    int                       job_w = 0;
    int                       job_h = 0;
    logic [OUT_ADDR_BITS-1:0] src_base = '0;
    logic [OUT_ADDR_BITS-1:0] dst_base = '0;
    logic [PIXEL_BITS-1:0]    job_value = '0;

    blit_cmd_t command_q[$];
    pixel_t    pixel_q[$];
    int        queued = 0;
    int        accepted = 0;
    int        mismatches = 0;
    int        cycles = 0;

    blit_cmd_t on_bus;
    int        burst_left = 0;
    int        gap_left = 0;
    logic      next_valid;

    int   rx_mode = 0;
    int   rx_left = 0;
    int   rx_hold = 0;
    int   rx_tick = 0;
    logic rx_ready;

    pixel_t want;

    function automatic int fit_span(int want_span, int start, int limit);
        int room;
        room = (start >= limit) ? 0 : limit - start;
        return (want_span < room) ? want_span : room;
    endfunction

    task automatic size_job(input blit_cmd_t c, output int w, output int h);
        if (c.cmd == CMD_START_FILL && c.full) begin
            w = dst_w;
            h = dst_h;
        end else if (c.cmd == CMD_START_COPY && c.full) begin
            w = src_w;
            h = src_h;
        end else begin
            w = fit_span(c.rw, c.dx, dst_w);
            h = fit_span(c.rh, c.dy, dst_h);
        end
        if (w > MAX_DIM) w = MAX_DIM;
        if (h > MAX_DIM) h = MAX_DIM;
    endtask

    task automatic predict_pixel(input blit_cmd_t c);
        int     w;
        int     h;
        longint sb;
        longint db;
        pixel_t px;
        if (c.cmd == CMD_START_COPY || c.cmd == CMD_START_FILL) begin
            size_job(c, w, h);
            sb = 0;
            db = 0;
            if (!(c.cmd == CMD_START_FILL && c.full))
                db = longint'(c.dy) * dst_w + c.dx;
            if (c.cmd == CMD_START_COPY && !c.full)
                sb = longint'(c.sy) * src_w + c.sx;
            job_fill  = (c.cmd == CMD_START_FILL);
            job_w     = w;
            job_h     = h;
            job_row   = 0;
            job_col   = 0;
            src_base  = sb[OUT_ADDR_BITS-1:0];
            dst_base  = db[OUT_ADDR_BITS-1:0];
            job_value = byte_px ? {24'd0, c.fv[7:0]} : c.fv;
            job_busy  = (w != 0 && h != 0);
        end else if (c.cmd == CMD_STEP && job_busy) begin
            px.src_addr = job_fill ? '0 : src_base + OUT_ADDR_BITS'(job_col);
            px.dst_addr = dst_base + OUT_ADDR_BITS'(job_col);
            px.is_fill  = job_fill;
            px.value    = job_fill ? job_value : '0;
            px.last     = (job_col + 1 == job_w) && (job_row + 1 == job_h);
            pixel_q.push_back(px);
            job_col++;
            if (job_col >= job_w) begin
                job_col = 0;
                job_row++;
                src_base = src_base + OUT_ADDR_BITS'(src_w);
                dst_base = dst_base + OUT_ADDR_BITS'(dst_w);
                if (job_row >= job_h) job_busy = 1'b0;
            end
        end
    endtask

    function automatic logic [S_TDATA_BITS-1:0] pack_cmd(blit_cmd_t c);
        return S_TDATA_BITS'({c.fv, c.rh, c.rw, c.dy, c.dx, c.sy, c.sx});
    endfunction

    // Sender: bursts of random length separated by random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_pixel(on_bus);
                accepted++;
            end
            if (s_tvalid && !s_tready) begin
                next_valid = 1'b1;
            end else if (gap_left > 0) begin
                gap_left--;
                next_valid = 1'b0;
            end else if (command_q.size() > 0) begin
                on_bus = command_q.pop_front();
                s_tdata <= pack_cmd(on_bus);
                s_tuser <= {on_bus.full, on_bus.cmd};
                next_valid = 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 24);
                    gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                next_valid = 1'b0;
            end
            s_tvalid <= next_valid;
        end
    end

    // Receiver: changes between always ready, random, periodic and long stalls.
    always @(posedge aclk) begin
        rx_tick++;
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(32, 256);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            0: begin
                rx_ready = 1'b1;
            end
            1: begin
                rx_ready = ($urandom_range(0, 3) != 0);
            end
            2: begin
                rx_ready = (rx_tick % 3 == 0);
            end
            default: begin
                if (rx_hold > 0) begin
                    rx_hold--;
                    rx_ready = 1'b0;
                end else begin
                    rx_ready = 1'b1;
                    if ($urandom_range(0, 7) == 0) rx_hold = $urandom_range(1, 12);
                end
            end
        endcase
        m_tready <= rx_ready;
    end

    task automatic flag_field(input string name, input longint want_v, input longint got_v);
        if (want_v != got_v) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch in %s: expected %0h, got %0h", name, want_v, got_v);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pixel_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pixel item: dst %0h", m_tdata[47:24]);
            end else begin
                want = pixel_q.pop_front();
                flag_field("src_address", want.src_addr, m_tdata[23:0]);
                flag_field("dst_address", want.dst_addr, m_tdata[47:24]);
                flag_field("pixel_value", want.value, m_tdata[79:48]);
                flag_field("is_fill", want.is_fill, m_tuser);
                flag_field("last", want.last, m_tlast);
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > RUN_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic push_cmd(input blit_cmd_t c);
        command_q.push_back(c);
        queued++;
    endtask

    function automatic blit_cmd_t random_cmd(logic [1:0] cmd);
        blit_cmd_t c;
        c.cmd  = cmd;
        c.full = 1'($urandom_range(0, 1));
        c.sx   = COORD_BITS'($urandom);
        c.sy   = COORD_BITS'($urandom);
        c.dx   = COORD_BITS'($urandom);
        c.dy   = COORD_BITS'($urandom);
        c.rw   = DIM_BITS'($urandom_range(0, MAX_DIM));
        c.rh   = DIM_BITS'($urandom_range(0, MAX_DIM));
        c.fv   = $urandom;
        return c;
    endfunction

    task automatic push_steps(input int n);
        repeat (n) push_cmd(random_cmd(CMD_STEP));
    endtask

    task automatic push_start(input logic [1:0] cmd, input logic full, input int sx, input int sy,
                              input int dx, input int dy, input int rw, input int rh,
                              input logic [31:0] fv);
        blit_cmd_t c;
        c = '{cmd, full, COORD_BITS'(sx), COORD_BITS'(sy), COORD_BITS'(dx), COORD_BITS'(dy),
              DIM_BITS'(rw), DIM_BITS'(rh), fv};
        push_cmd(c);
    endtask

    function automatic int pick_corner(int extent);
        int k;
        int v;
        k = $urandom_range(0, 9);
        if (k < 4) v = $urandom_range(0, (extent < 4) ? extent - 1 : 3);
        else if (k < 7) v = $urandom_range(0, extent - 1);
        else if (k < 9) v = extent - $urandom_range(1, 3);
        else v = $urandom_range(0, 4095);
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return v;
    endfunction

    function automatic int pick_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 6);
        if (r < 88) return $urandom_range(0, MAX_DIM);
        if (r < 94) return 0;
        return MAX_DIM;
    endfunction

    // One job: mostly a start followed by all of its steps, sometimes cut
    // short by the next start, with stray steps and unused codes mixed in.
    task automatic plan_job();
        blit_cmd_t c;
        int        w;
        int        h;
        int        n;
        int        steps;
        c = random_cmd($urandom_range(0, 1) ? CMD_START_FILL : CMD_START_COPY);
        c.full = ($urandom_range(0, 99) < 15);
        c.dx = COORD_BITS'(pick_corner(dst_w));
        c.dy = COORD_BITS'(pick_corner(dst_h));
        c.rw = DIM_BITS'(pick_span());
        c.rh = DIM_BITS'(pick_span());
        size_job(c, w, h);
        n = w * h;
        push_cmd(c);
        if (n == 0)
            steps = 1;
        else if (n <= 48 && $urandom_range(0, 9) != 0)
            steps = n + (($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0);
        else
            steps = $urandom_range(1, (n < 40) ? n : 40);
        push_steps(steps);
        if ($urandom_range(0, 11) == 0) push_cmd(random_cmd(CMD_UNUSED));
    endtask

    task automatic settle();
        while (accepted != queued || pixel_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic poke(input logic [CFG_INDEX_BITS-1:0] idx, input int value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_BITS'(value);
    endtask

    task automatic set_surfaces(input int sw, input int sh, input int dw, input int dh,
                                input int bp);
        poke(CFG_SRC_WIDTH, sw);
        poke(CFG_SRC_HEIGHT, sh);
        poke(CFG_DST_WIDTH, dw);
        poke(CFG_DST_HEIGHT, dh);
        poke(CFG_BYTE_PIXELS, bp);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        src_w   = sw;
        src_h   = sh;
        dst_w   = dw;
        dst_h   = dh;
        byte_px = bp;
    endtask

    task automatic run_random();
        int mark;
        mark = queued;
        while (queued - mark < PHASE_ITEMS) plan_job();
        settle();
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed commands on the reset surface sizes.
        push_steps(1);
        push_cmd(random_cmd(CMD_UNUSED));
        push_start(CMD_START_COPY, 1'b0, 4095, 4095, 0, 0, 2, 2, 32'h0);
        push_steps(5);
        push_start(CMD_START_FILL, 1'b0, 0, 0, 399, 299, MAX_DIM, MAX_DIM, 32'hFFFF_FFFF);
        push_steps(1);
        push_start(CMD_START_COPY, 1'b0, 1, 1, 3, 3, 0, 5, 32'h0);
        push_steps(1);
        push_start(CMD_START_FILL, 1'b0, 0, 0, 4095, 5, 3, 3, 32'h1234_5678);
        push_steps(1);
        push_start(CMD_START_FILL, 1'b1, 0, 0, 7, 7, 0, 0, 32'h8000_0001);
        push_steps(3);
        push_start(CMD_START_COPY, 1'b1, 0, 0, 4095, 4095, 0, 0, 32'h0);
        push_steps(2);
        push_start(CMD_START_COPY, 1'b0, 10, 20, 398, 298, 5, 5, 32'h0);
        push_steps(4);
        settle();

        run_random();
        set_surfaces(1, 1, 1, 1, 1);
        run_random();
        set_surfaces(4096, 4096, 4096, 4096, 1);
        run_random();
        set_surfaces(3, 2, 4, 3, 0);
        run_random();
        set_surfaces(4096, 1, 5, 4096, 1);
        run_random();
        set_surfaces($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 16),
                     $urandom_range(1, 16), $urandom_range(0, 1));
        run_random();
        set_surfaces(400, 300, 400, 300, 0);
        run_random();

        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
